>>> design/cmrq_pkg.sv
// types and constants shared by the counted multiset range query block
// no dependencies; imported by the cell and the top level
package cmrq_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;
	localparam int IN_VAL_W   = 32;
	localparam int IN_CNT_W   = 16;
	localparam int SPREAD_W   = 32;
	// width in which a remove count and a copy count are compared
	localparam int CMP_W = (COUNT_BITS > IN_CNT_W) ? COUNT_BITS : IN_CNT_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// command modes; any other code is a query
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]          mode;
		logic [IN_VAL_W-1:0] value;
		logic [IN_CNT_W-1:0] count;
	} in_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [SPREAD_W-1:0] spread;
	} out_t;

	// contents of one cell of the sorted row
	typedef struct packed {
		logic                  used;
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] copies;
	} cell_t;

	// operand broadcast to every cell
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [CMP_W-1:0]      count;
	} op_t;

	// per-cell compare results
	typedef struct packed {
		logic ge;    // free, or holds a value above the operand
		logic geq;   // free, or holds a value at or above the operand
		logic eq;    // holds the operand
		logic kill;  // holds the operand and the remove takes every copy
	} flag_t;

	// row-wide update decided from all cells' flags
	typedef struct packed {
		logic ins_new;
		logic ins_bump;
		logic del_shift;
		logic del_sub;
	} ctrl_t;

endpackage

>>> design/cmrq_cell.sv
// one cell of the sorted row: a value, its copy count and a used bit
// depends on cmrq_pkg; instanced once per table entry by the top level
module cmrq_cell import cmrq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  op_t   op,
	input  ctrl_t ctrl,
	input  flag_t left_flag,
	input  cell_t left_cell,
	input  cell_t right_cell,
	output cell_t slot,
	output flag_t flag,
	output logic  tail
);

	logic                  used_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [COUNT_BITS-1:0] copies_q;
	cell_t                 next;

	assign slot = '{used: used_q, value: value_q, copies: copies_q};

	// compare against the broadcast operand
	always_comb begin
		flag.eq   = used_q && (value_q == op.value);
		flag.ge   = !used_q || (value_q > op.value);
		flag.geq  = flag.ge || flag.eq;
		flag.kill = flag.eq && (op.count >= CMP_W'(copies_q));
	end

	// last used cell of the row holds the largest value
	assign tail = used_q && !right_cell.used;

	// next contents: shift right to open a gap, shift left to close one, or edit in place
	always_comb begin
		next = slot;
		if (ctrl.ins_new) begin
			if (left_flag.ge) begin
				next = left_cell;
			end else if (flag.ge) begin
				next = '{used: 1'b1, value: op.value, copies: COUNT_ONE};
			end
		end else if (ctrl.ins_bump) begin
			if (flag.eq && copies_q != COUNT_MAX) begin
				next.copies = copies_q + COUNT_ONE;
			end
		end else if (ctrl.del_shift) begin
			if (flag.geq) begin
				next = right_cell;
			end
		end else if (ctrl.del_sub) begin
			if (flag.eq) begin
				next.copies = COUNT_BITS'(CMP_W'(copies_q) - op.count);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			copies_q <= '0;
		end else begin
			used_q   <= next.used;
			copies_q <= next.used ? next.copies : '0;
		end
	end

	// stored value, meaningful only while used
	always_ff @(posedge clk) begin
		value_q <= next.value;
	end

endmodule

>>> design/counted_multiset_range_query.sv
// top level of the counted multiset range query block
// depends on cmrq_pkg and cmrq_cell; holds the command register, the cell row and the result

// A command beat is taken when start is high and busy is low; busy then stays high for
// one cycle, so no command is taken while busy is high. In that cycle every cell of
// the sorted row compares the value at once and the whole row shifts or edits in a
// single step; the result appears on rsp with done high for exactly one cycle at the
// end of it and must be taken then, as there is no way to hold it off. Values are kept
// in ascending order from cell 0, so the smallest and largest sit at the two ends of the
// used part of the row. The table is empty straight out of reset, with no clearing pass.
module counted_multiset_range_query import cmrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  cmd,
	output logic done,
	output out_t rsp
);

	logic  busy_q;
	in_t   cmd_q;
	logic  done_q;
	out_t  rsp_q;
	op_t   op;
	ctrl_t ctrl;
	cell_t cells [CAPACITY];
	flag_t flags [CAPACITY];
	logic [CAPACITY-1:0] eq_v;
	logic [CAPACITY-1:0] kill_v;
	logic [CAPACITY-1:0] tail_v;
	logic                any_eq;
	logic                any_kill;
	logic                full;
	logic                is_ins;
	logic                is_rem;
	logic [VALUE_BITS-1:0] hi;
	logic [VALUE_BITS-1:0] diff;
	out_t                rsp_d;

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// command register, one beat in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			cmd_q <= cmd;
		end
	end

	assign op.value = VALUE_BITS'(cmd_q.value);
	assign op.count = CMP_W'(cmd_q.count);
	assign is_ins   = cmd_q.mode == MODE_INSERT;
	assign is_rem   = cmd_q.mode == MODE_REMOVE;

	// the row of cells, each linked to both neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		flag_t left_flag;
		cell_t left_cell;
		cell_t right_cell;

		if (i == 0) begin : g_first
			assign left_flag = '0;
			assign left_cell = '0;
		end else begin : g_mid
			assign left_flag = flags[i-1];
			assign left_cell = cells[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_cell = '0;
		end else begin : g_inner
			assign right_cell = cells[i+1];
		end

		cmrq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.ctrl       (ctrl),
			.left_flag  (left_flag),
			.left_cell  (left_cell),
			.right_cell (right_cell),
			.slot       (cells[i]),
			.flag       (flags[i]),
			.tail       (tail_v[i])
		);

		assign eq_v[i]   = flags[i].eq;
		assign kill_v[i] = flags[i].kill;
	end

	// row-wide decisions
	assign any_eq   = |eq_v;
	assign any_kill = |kill_v;
	assign full     = cells[CAPACITY-1].used;

	always_comb begin
		ctrl.ins_new   = busy_q && is_ins && !any_eq && !full;
		ctrl.ins_bump  = busy_q && is_ins && any_eq;
		ctrl.del_shift = busy_q && is_rem && any_kill;
		ctrl.del_sub   = busy_q && is_rem && any_eq && !any_kill;
	end

	// largest value sits in the last used cell
	always_comb begin
		hi = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hi = hi | (tail_v[i] ? cells[i].value : '0);
		end
	end

	assign diff = hi - cells[0].value;

	// result beat
	always_comb begin
		rsp_d.status = ST_OK;
		rsp_d.spread = '0;
		if (is_ins) begin
			if (!any_eq && full) begin
				rsp_d.status = ST_FULL;
			end
		end else if (!is_rem) begin
			if (cells[0].used) begin
				rsp_d.spread = SPREAD_W'(diff);
			end else begin
				rsp_d.status = ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
